>>> hw/rtl/gara_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the grid atlas rectangle allocator: field widths,
// default geometry, result status codes and the shift direction type.
// No dependencies.

package gara_pkg;

   // Port field widths.
   localparam int RECT_W     = 10;
   localparam int STATUS_W   = 2;
   localparam int PAGE_IDX_W = 2;
   localparam int POS_W      = 9;

   // Default geometry, handed to the top level parameters.
   localparam int PAGE_SIZE_DEF   = 512;
   localparam int CELL_STEP_DEF   = 8;
   localparam int MAX_ATLASES_DEF = 4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_PLACED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NEW_PAGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd2;

   // Direction control of the shared shifter.
   typedef enum logic {
      SHIFT_RIGHT,
      SHIFT_LEFT
   } shift_dir_type;

endpackage

>>> hw/rtl/gara_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.

module gara_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/gara_shifter.sv
`timescale 1ns / 1ps
// Shared logical barrel shifter used for row window folding and span masks.
// Depends on gara_pkg for the shift direction type.

module gara_shifter #(
   parameter int WIDTH = 64,
   parameter int AMT_W = 7
) (
   input  logic [WIDTH-1:0]            operand,
   input  logic [AMT_W-1:0]            amount,
   input  gara_pkg::shift_dir_type     dir,
   output logic [WIDTH-1:0]            result
);

   // Amounts of WIDTH or more shift everything out, leaving zeros.
   always_comb begin
      if (dir == gara_pkg::SHIFT_LEFT) begin
         result = operand << amount;
      end else begin
         result = operand >> amount;
      end
   end

endmodule

>>> hw/rtl/grid_atlas_rect_allocator.sv
`timescale 1ns / 1ps
// Top level of the grid atlas rectangle allocator: sequencer, page scan and marking.
// Depends on gara_pkg, gara_ram and gara_shifter.
//
//  Channel   Ports                                   Handshake
//  --------  --------------------------------------  -------------------------------
//  request   req_rect_width, req_rect_height         transfer when start && !busy
//  response  rsp_status, rsp_page_index,             one-cycle strobe on rsp_valid,
//            rsp_x_pos, rsp_y_pos                    cannot be held off
//
// After reset the block sweeps the occupancy RAM once, one row per cycle, so busy
// stays high through all MAX_ATLASES * (PAGE_SIZE / CELL_STEP) rows (256 by default).
// A request then goes through setup (the transfer cycle, two rounding steps and the
// checks), and unless the checks settle it, a scan of the open pages in order until
// one fits and a marking pass for the placement. A page scan reads each of its CELLS
// rows and folds the row through the shared shifter in doubling steps and a final
// shift by the remainder, and a closing step ends each page. Marking builds the span
// mask and then reads and rewrites each covered row, and the response strobe follows.
// busy stays high from the accepted transfer to the response strobe.

module grid_atlas_rect_allocator #(
   parameter int PAGE_SIZE   = gara_pkg::PAGE_SIZE_DEF,
   parameter int CELL_STEP   = gara_pkg::CELL_STEP_DEF,
   parameter int MAX_ATLASES = gara_pkg::MAX_ATLASES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [gara_pkg::RECT_W-1:0]       req_rect_width,
   input  logic [gara_pkg::RECT_W-1:0]       req_rect_height,
   output logic                              rsp_valid,
   output logic [gara_pkg::STATUS_W-1:0]     rsp_status,
   output logic [gara_pkg::PAGE_IDX_W-1:0]   rsp_page_index,
   output logic [gara_pkg::POS_W-1:0]        rsp_x_pos,
   output logic [gara_pkg::POS_W-1:0]        rsp_y_pos
);

   // Geometry. One RAM word holds one row of cells of one page.
   localparam int CELLS   = PAGE_SIZE / CELL_STEP;
   localparam int DEPTH   = MAX_ATLASES * CELLS;
   localparam int AW      = $clog2(DEPTH);
   localparam int AMT_W   = $clog2(CELLS + 1);
   localparam int CX_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int K_W     = $clog2(AMT_W) + 1;
   localparam int PG_W    = (MAX_ATLASES > 1) ? $clog2(MAX_ATLASES) : 1;
   localparam int PO_W    = $clog2(MAX_ATLASES + 1);

   // Rounding up to cells is a multiply by a scaled reciprocal of CELL_STEP.
   // With a shift of DIVN_W + ceil(log2(CELL_STEP)) the quotient is exact
   // for every numerator below 2**DIVN_W.
   localparam int DIVN_W  = gara_pkg::RECT_W + 1;
   localparam int STEP_L  = $clog2(CELL_STEP);
   localparam int DIV_SH  = DIVN_W + STEP_L;
   localparam int PROD_W  = DIV_SH + DIVN_W;
   localparam int RECIP_W = DIVN_W + 2;
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((1 << DIV_SH) + CELL_STEP - 1) / CELL_STEP);

   // Sequencer state codes.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLEAR = 4'd1;
   localparam logic [3:0] ST_DIVW  = 4'd2;
   localparam logic [3:0] ST_DIVH  = 4'd3;
   localparam logic [3:0] ST_CHECK = 4'd4;
   localparam logic [3:0] ST_RD    = 4'd5;
   localparam logic [3:0] ST_LD    = 4'd6;
   localparam logic [3:0] ST_DBL   = 4'd7;
   localparam logic [3:0] ST_FIN   = 4'd8;
   localparam logic [3:0] ST_PEND  = 4'd9;
   localparam logic [3:0] ST_MK0   = 4'd10;
   localparam logic [3:0] ST_MK1   = 4'd11;
   localparam logic [3:0] ST_MRD   = 4'd12;
   localparam logic [3:0] ST_MWR   = 4'd13;
   localparam logic [3:0] ST_RESP  = 4'd14;

   // Control registers (reset).
   logic [3:0]       state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [PO_W-1:0]  pages_open_ff, pages_open_in;

   // Working registers (no reset needed).
   logic [gara_pkg::RECT_W-1:0] w_ff, w_in, h_ff, h_in;
   logic [DIVN_W-1:0]           bw_ff, bw_in, bh_ff, bh_in;
   logic [K_W-1:0]              lg_ff, lg_in, k_ff, k_in;
   logic [AMT_W-1:0]            rem_ff, rem_in;
   logic [PG_W-1:0]             page_ff, page_in;
   logic [AW-1:0]               base_ff, base_in;
   logic [CX_W-1:0]             row_ff, row_in;
   logic [AMT_W-1:0]            mleft_ff, mleft_in;
   logic [CELLS-1:0]            cur_ff, cur_in;
   logic [CELLS-1:0]            mask_ff, mask_in;
   logic                        found_ff, found_in;
   logic [CX_W-1:0]             best_cx_ff, best_cx_in;
   logic [CX_W-1:0]             best_cy_ff, best_cy_in;
   logic [AMT_W-1:0]            run_ff [CELLS];
   logic [AMT_W-1:0]            run_in [CELLS];

   logic [gara_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [gara_pkg::PAGE_IDX_W-1:0] rsp_page_ff, rsp_page_in;
   logic [gara_pkg::POS_W-1:0]      rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   // Divider datapath.
   logic [gara_pkg::RECT_W-1:0] div_src;
   logic [DIVN_W-1:0]           div_n;
   logic [PROD_W-1:0]           div_prod;
   logic [DIVN_W-1:0]           div_q;

   // Narrow views of the rounded sizes, valid once the oversize check passed.
   logic [AMT_W-1:0] bw_n, bh_n;
   logic             oversize;

   // Shared shifter.
   logic [CELLS-1:0]        sh_op, sh_res;
   logic [AMT_W-1:0]        sh_amt;
   gara_pkg::shift_dir_type sh_dir;

   // Row scan results.
   logic [CELLS-1:0] fit_vec, newhit;
   logic             hit_any;
   logic [CX_W-1:0]  hit_cx;
   logic [AMT_W:0]   cy_calc;
   logic [K_W-1:0]   lg_calc;

   // RAM ports.
   logic             ram_wr_en, ram_rd_en;
   logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [CELLS-1:0] ram_wr_data, ram_rd_data;

   gara_ram #(
      .WIDTH (CELLS),
      .DEPTH (DEPTH)
   ) u_occupancy (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   gara_shifter #(
      .WIDTH (CELLS),
      .AMT_W (AMT_W)
   ) u_shifter (
      .operand (sh_op),
      .amount  (sh_amt),
      .dir     (sh_dir),
      .result  (sh_res)
   );

   // Sizes in cells: one multiplier, shared between width and height.
   assign div_src  = (state_ff == ST_DIVW) ? w_ff : h_ff;
   assign div_n    = DIVN_W'(div_src) + DIVN_W'(CELL_STEP - 1);
   assign div_prod = PROD_W'(div_n) * PROD_W'(DIV_RECIP);
   assign div_q    = div_prod[DIV_SH +: DIVN_W];

   assign oversize = (int'(bw_ff) > CELLS) || (int'(bh_ff) > CELLS);
   assign bw_n     = AMT_W'(bw_ff);
   assign bh_n     = AMT_W'(bh_ff);

   // Floor of log2 of the width in cells, for the window fold.
   always_comb begin
      lg_calc = '0;
      for (int i = 0; i < AMT_W; i++) begin
         if (bw_n[i]) begin
            lg_calc = K_W'(i);
         end
      end
   end

   // Shifter operand selection. A row of free bits is folded so that bit x ends
   // up set when cells x .. x+w-1 are all free: doubling steps build windows of
   // 2**lg cells, and a final shift by the remainder overlaps two such windows.
   always_comb begin
      sh_op  = cur_ff;
      sh_amt = '0;
      sh_dir = gara_pkg::SHIFT_RIGHT;
      unique case (state_ff)
         ST_DBL: begin
            sh_amt = AMT_W'(1) << k_ff;
         end
         ST_FIN: begin
            sh_amt = rem_ff;
         end
         ST_MK0: begin
            sh_op  = '1;
            sh_amt = bw_n;
            sh_dir = gara_pkg::SHIFT_LEFT;
         end
         ST_MK1: begin
            sh_op  = mask_ff;
            sh_amt = AMT_W'(best_cx_ff);
            sh_dir = gara_pkg::SHIFT_LEFT;
         end
         default: begin
            sh_op = cur_ff;
         end
      endcase
   end

   // Vertical runs: each x lane counts consecutive rows in which the width fits.
   // A lane whose run reaches the height for the first time marks a fit whose
   // top row is row - h + 1, the lowest such row for that lane.
   assign fit_vec = cur_ff & sh_res;

   always_comb begin
      newhit = '0;
      for (int l = 0; l < CELLS; l++) begin
         run_in[l] = run_ff[l];
         if ((state_ff == ST_CHECK) || (state_ff == ST_PEND)) begin
            run_in[l] = '0;
         end else if (state_ff == ST_FIN) begin
            if (fit_vec[l]) begin
               run_in[l] = (run_ff[l] == bh_n) ? bh_n : AMT_W'(run_ff[l] + 1'b1);
               newhit[l] = (run_ff[l] == AMT_W'(bh_n - 1'b1));
            end else begin
               run_in[l] = '0;
            end
         end
      end
   end

   always_comb begin
      hit_cx = '0;
      for (int l = CELLS - 1; l >= 0; l--) begin
         if (newhit[l]) begin
            hit_cx = CX_W'(l);
         end
      end
   end

   assign hit_any = |newhit;
   assign cy_calc = (AMT_W + 1)'(row_ff) + (AMT_W + 1)'(1) - (AMT_W + 1)'(bh_n);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      pages_open_in = pages_open_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      bw_in         = bw_ff;
      bh_in         = bh_ff;
      lg_in         = lg_ff;
      k_in          = k_ff;
      rem_in        = rem_ff;
      page_in       = page_ff;
      base_in       = base_ff;
      row_in        = row_ff;
      mleft_in      = mleft_ff;
      cur_in        = cur_ff;
      mask_in       = mask_ff;
      found_in      = found_ff;
      best_cx_in    = best_cx_ff;
      best_cy_in    = best_cy_ff;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = base_ff + AW'(row_ff);
      ram_wr_data   = ram_rd_data | mask_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = base_ff + AW'(row_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = AW'(clr_ff + 1'b1);
            if (int'(clr_ff) == DEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               w_in     = req_rect_width;
               h_in     = req_rect_height;
               state_in = ST_DIVW;
            end
         end
         ST_DIVW: begin
            bw_in    = div_q;
            state_in = ST_DIVH;
         end
         ST_DIVH: begin
            bh_in    = div_q;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            lg_in      = lg_calc;
            rem_in     = AMT_W'(bw_n - (AMT_W'(1) << lg_calc));
            page_in    = '0;
            base_in    = '0;
            row_in     = '0;
            found_in   = 1'b0;
            best_cx_in = '0;
            best_cy_in = '0;
            rsp_page_in = '0;
            rsp_x_in    = '0;
            rsp_y_in    = '0;
            if (oversize) begin
               rsp_status_in = gara_pkg::STATUS_NO_SPACE;
               state_in      = ST_RESP;
            end else if ((bw_ff == '0) || (bh_ff == '0)) begin
               // An empty rectangle covers nothing and lands at the origin of
               // page 0, which is opened here if no page exists yet.
               if (pages_open_ff != '0) begin
                  rsp_status_in = gara_pkg::STATUS_PLACED;
               end else begin
                  rsp_status_in = gara_pkg::STATUS_NEW_PAGE;
                  pages_open_in = PO_W'(1);
               end
               state_in = ST_RESP;
            end else if (pages_open_ff == '0) begin
               rsp_status_in = gara_pkg::STATUS_NEW_PAGE;
               pages_open_in = PO_W'(1);
               state_in      = ST_MK0;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_LD;
         end
         ST_LD: begin
            cur_in   = ~ram_rd_data;
            k_in     = '0;
            state_in = (lg_ff == '0) ? ST_FIN : ST_DBL;
         end
         ST_DBL: begin
            cur_in = cur_ff & sh_res;
            k_in   = K_W'(k_ff + 1'b1);
            if (K_W'(k_ff + 1'b1) == lg_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (hit_any && (!found_ff || (hit_cx < best_cx_ff))) begin
               found_in   = 1'b1;
               best_cx_in = hit_cx;
               best_cy_in = CX_W'(cy_calc);
            end
            if (int'(row_ff) == CELLS - 1) begin
               state_in = ST_PEND;
            end else begin
               row_in   = CX_W'(row_ff + 1'b1);
               state_in = ST_RD;
            end
         end
         ST_PEND: begin
            row_in = '0;
            if (found_ff) begin
               rsp_status_in = gara_pkg::STATUS_PLACED;
               state_in      = ST_MK0;
            end else if (PO_W'(page_ff) + PO_W'(1) < pages_open_ff) begin
               page_in  = PG_W'(page_ff + 1'b1);
               base_in  = base_ff + AW'(CELLS);
               state_in = ST_RD;
            end else if (int'(pages_open_ff) < MAX_ATLASES) begin
               page_in       = PG_W'(page_ff + 1'b1);
               base_in       = base_ff + AW'(CELLS);
               pages_open_in = PO_W'(pages_open_ff + 1'b1);
               best_cx_in    = '0;
               best_cy_in    = '0;
               rsp_status_in = gara_pkg::STATUS_NEW_PAGE;
               state_in      = ST_MK0;
            end else begin
               rsp_status_in = gara_pkg::STATUS_NO_SPACE;
               state_in      = ST_RESP;
            end
         end
         ST_MK0: begin
            mask_in     = ~sh_res;
            rsp_page_in = gara_pkg::PAGE_IDX_W'(page_ff);
            rsp_x_in    = gara_pkg::POS_W'(int'(best_cx_ff) * CELL_STEP);
            rsp_y_in    = gara_pkg::POS_W'(int'(best_cy_ff) * CELL_STEP);
            state_in    = ST_MK1;
         end
         ST_MK1: begin
            mask_in  = sh_res;
            row_in   = best_cy_ff;
            mleft_in = bh_n;
            state_in = ST_MRD;
         end
         ST_MRD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_MWR;
         end
         ST_MWR: begin
            ram_wr_en = 1'b1;
            row_in    = CX_W'(row_ff + 1'b1);
            mleft_in  = AMT_W'(mleft_ff - 1'b1);
            state_in  = (mleft_ff == AMT_W'(1)) ? ST_RESP : ST_MRD;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         pages_open_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pages_open_ff <= pages_open_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff          <= w_in;
      h_ff          <= h_in;
      bw_ff         <= bw_in;
      bh_ff         <= bh_in;
      lg_ff         <= lg_in;
      k_ff          <= k_in;
      rem_ff        <= rem_in;
      page_ff       <= page_in;
      base_ff       <= base_in;
      row_ff        <= row_in;
      mleft_ff      <= mleft_in;
      cur_ff        <= cur_in;
      mask_ff       <= mask_in;
      found_ff      <= found_in;
      best_cx_ff    <= best_cx_in;
      best_cy_ff    <= best_cy_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      for (int l = 0; l < CELLS; l++) begin
         run_ff[l] <= run_in[l];
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_RESP);
   assign rsp_status     = rsp_status_ff;
   assign rsp_page_index = rsp_page_ff;
   assign rsp_x_pos      = rsp_x_ff;
   assign rsp_y_pos      = rsp_y_ff;

   // The response strobe lasts exactly one cycle and is followed by idle.
   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("response strobe longer than one cycle");

   // The number of open pages never exceeds the cap.
   a_pages_cap : assert property (@(posedge clock) disable iff (reset)
      int'(pages_open_ff) <= MAX_ATLASES)
      else $error("open page count above cap");

   // A no-space result carries zero placement fields.
   a_no_space_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == gara_pkg::STATUS_NO_SPACE)) |->
         (rsp_page_index == '0) && (rsp_x_pos == '0) && (rsp_y_pos == '0))
      else $error("no-space result with nonzero placement");

   // A new-page result names the page that was just opened, at its origin.
   a_new_page : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == gara_pkg::STATUS_NEW_PAGE)) |->
         (rsp_page_index == gara_pkg::PAGE_IDX_W'(pages_open_ff - 1'b1)) &&
         (rsp_x_pos == '0) && (rsp_y_pos == '0))
      else $error("new-page result does not match the opened page");

   // No request is taken while the clearing pass is running.
   a_clear_busy : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> busy && !rsp_valid)
      else $error("block not busy during clearing pass");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for grid_atlas_rect_allocator: directed and random rectangle
// requests, checked against a first-fit packing predictor kept inside this file.
// Depends on gara_pkg and the grid_atlas_rect_allocator RTL.

module tb;

   // Geometry the block is built with here; the predictor works in grid cells.
   localparam int CELLS     = gara_pkg::PAGE_SIZE_DEF / gara_pkg::CELL_STEP_DEF;
   localparam int MAX_PAGES = gara_pkg::MAX_ATLASES_DEF;
   localparam int STEP      = gara_pkg::CELL_STEP_DEF;

   // A request over four full pages scans every row of each. The limit covers the
   // slowest request for every item, the sender's gaps and the clearing sweep after
   // reset, several times over.
   localparam int CYCLE_LIMIT = 6_000_000;
   // Quiet time after the last response, longer than any single request.
   localparam int TAIL_CYCLES = 3000;

   typedef struct packed {
      logic [gara_pkg::STATUS_W-1:0]   status;
      logic [gara_pkg::PAGE_IDX_W-1:0] page;
      logic [gara_pkg::POS_W-1:0]      x_pos;
      logic [gara_pkg::POS_W-1:0]      y_pos;
   } placement_type;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [gara_pkg::RECT_W-1:0]     req_rect_width;
   logic [gara_pkg::RECT_W-1:0]     req_rect_height;
   logic                            rsp_valid;
   logic [gara_pkg::STATUS_W-1:0]   rsp_status;
   logic [gara_pkg::PAGE_IDX_W-1:0] rsp_page_index;
   logic [gara_pkg::POS_W-1:0]      rsp_x_pos;
   logic [gara_pkg::POS_W-1:0]      rsp_y_pos;

   // Predictor state: one occupancy bit per grid cell, a row vector per cell row.
   // A page is cleared when it is opened, so rows of unopened pages are never read.
   logic [CELLS-1:0] cell_map [MAX_PAGES][CELLS];
   int               pages_opened = 0;

   // Placements predicted at each accepted request, oldest first.
   placement_type placements_due[$];

   int failures          = 0;
   int requests_sent     = 0;
   int responses_checked = 0;
   int placed_count      = 0;
   int opened_count      = 0;
   int refused_count     = 0;
   int sender_idle_pct   = 0;
   int cycle_count       = 0;

   grid_atlas_rect_allocator DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_page_index  (rsp_page_index),
      .rsp_x_pos       (rsp_x_pos),
      .rsp_y_pos       (rsp_y_pos)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // First-fit placement. Sizes round up to whole cells. Open pages are tried in
   // order; within a page the x positions form the outer loop and y the inner one.
   // For one x position the first free y is where a run of free rows first reaches
   // the rectangle height, which replaces the inner loop over y with a single pass.
   function automatic placement_type place_rect(
         input logic [gara_pkg::RECT_W-1:0] width,
         input logic [gara_pkg::RECT_W-1:0] height);
      int               cols;
      int               rows;
      int               pg;
      int               cx;
      int               r;
      int               run;
      int               hit_page;
      int               hit_x;
      int               hit_y;
      logic [CELLS-1:0] span;
      placement_type    result;
      result        = '0;
      result.status = gara_pkg::STATUS_NO_SPACE;
      cols = (int'(width) + STEP - 1) / STEP;
      rows = (int'(height) + STEP - 1) / STEP;
      // A side longer than a page is refused before any page is opened.
      if (cols > CELLS || rows > CELLS) begin
         refused_count++;
         return result;
      end
      hit_page = -1;
      hit_x    = 0;
      hit_y    = 0;
      if (cols == 0 || rows == 0) begin
         // An empty rectangle covers no cells and fits at the origin of page 0.
         if (pages_opened > 0) begin
            hit_page = 0;
         end
      end else begin
         for (pg = 0; pg < pages_opened && hit_page < 0; pg++) begin
            for (cx = 0; cx + cols <= CELLS && hit_page < 0; cx++) begin
               span = ~({CELLS{1'b1}} << cols) << cx;
               run  = 0;
               for (r = 0; r < CELLS && hit_page < 0; r++) begin
                  if ((cell_map[pg][r] & span) == '0) begin
                     run++;
                  end else begin
                     run = 0;
                  end
                  if (run == rows) begin
                     hit_page = pg;
                     hit_x    = cx;
                     hit_y    = r - rows + 1;
                  end
               end
            end
         end
      end
      if (hit_page >= 0) begin
         result.status = gara_pkg::STATUS_PLACED;
         placed_count++;
      end else if (pages_opened < MAX_PAGES) begin
         // Nothing fits in the open pages: a fresh page takes it at its origin.
         hit_page = pages_opened;
         pages_opened++;
         for (r = 0; r < CELLS; r++) begin
            cell_map[hit_page][r] = '0;
         end
         result.status = gara_pkg::STATUS_NEW_PAGE;
         opened_count++;
      end else begin
         // Every page is open and none has room.
         refused_count++;
         return result;
      end
      span = ~({CELLS{1'b1}} << cols) << hit_x;
      for (r = hit_y; r < hit_y + rows; r++) begin
         cell_map[hit_page][r] |= span;
      end
      result.page  = gara_pkg::PAGE_IDX_W'(hit_page);
      result.x_pos = gara_pkg::POS_W'(hit_x * STEP);
      result.y_pos = gara_pkg::POS_W'(hit_y * STEP);
      return result;
   endfunction

   // Sends one request and records its predicted placement once the transfer
   // happens. Inputs change only at falling edges. When the sender idles, start
   // drops, the task waits for the block to finish its current request and then
   // holds off a few more cycles, so gaps land just after busy falls as well as
   // well after it. Otherwise start goes high at once and waits through busy.
   // The task returns at a falling edge with start still high; the next call or
   // the end of the run decides its next value.
   task automatic send_rect(input logic [gara_pkg::RECT_W-1:0] width,
                            input logic [gara_pkg::RECT_W-1:0] height);
      placement_type predicted;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(negedge clock); while (busy);
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      start           <= 1'b1;
      req_rect_width  <= width;
      req_rect_height <= height;
      do @(posedge clock); while (busy);
      // The transfer took place at this rising edge.
      predicted      = place_rect(width, height);
      placements_due = {placements_due, predicted};
      requests_sent++;
      @(negedge clock);
   endtask

   function automatic void check_field(input string name, input logic [15:0] expected_val,
                                       input logic [15:0] actual_val);
      if (actual_val !== expected_val) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected_val, actual_val);
         failures++;
      end
   endfunction

   // Each response strobe lasts one cycle and is taken at the rising edge that
   // ends it. Sampling at the edge sees the values from before any update there.
   always @(posedge clock) begin : response_check
      placement_type due;
      if (!reset && rsp_valid) begin
         if (placements_due.size() == 0) begin
            $error("Response with no request outstanding: status %0d page %0d (%0d,%0d)",
                   rsp_status, rsp_page_index, rsp_x_pos, rsp_y_pos);
            failures++;
         end else begin
            due = placements_due.pop_front();
            check_field("status", 16'(due.status), 16'(rsp_status));
            check_field("page_index", 16'(due.page), 16'(rsp_page_index));
            check_field("x_pos", 16'(due.x_pos), 16'(rsp_x_pos));
            check_field("y_pos", 16'(due.y_pos), 16'(rsp_y_pos));
            responses_checked++;
         end
      end
   end

   // Empty rectangles: with no page open one opens page 0; later ones land at the
   // origin of page 0 without marking anything. An oversize side still wins over an
   // empty one.
   task automatic test_zero_size();
      send_rect(10'd0, 10'd0);
      send_rect(10'd0, 10'd300);
      send_rect(10'd777, 10'd0);
      send_rect(10'd1023, 10'd0);
      send_rect(10'd0, 10'd517);
   endtask

   // Pixel sizes that round up to whole cells, packed first-fit into page 0.
   task automatic test_rounding();
      send_rect(10'd1, 10'd1);
      send_rect(10'd8, 10'd8);
      send_rect(10'd9, 10'd9);
      send_rect(10'd7, 10'd17);
      send_rect(10'd16, 10'd1);
   endtask

   // Sides longer than a page, down to one pixel over, are refused; no page is opened for them.
   task automatic test_oversize();
      send_rect(10'd513, 10'd1);
      send_rect(10'd1, 10'd513);
      send_rect(10'd1023, 10'd1023);
      send_rect(10'd520, 10'd520);
   endtask

   // A full page cannot share page 0 and opens page 1. A full-width strip then
   // fits under the earlier rectangles, after which a full-height column fits
   // nowhere and opens another page with most of it still free.
   task automatic test_full_page();
      send_rect(10'd512, 10'd512);
      send_rect(10'd512, 10'd8);
      send_rect(10'd8, 10'd512);
   endtask

   // Random requests, mostly small so the pages fill gradually: new pages open,
   // later requests slot into gaps in older pages, and once all pages are open
   // larger requests start to be refused. A few empty, oversize and large ones
   // are mixed in.
   task automatic test_random_fill(input int count, input int idle_pct);
      logic [gara_pkg::RECT_W-1:0] width;
      logic [gara_pkg::RECT_W-1:0] height;
      int                          pick;
      sender_idle_pct = idle_pct;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            if ($urandom_range(0, 1) == 1) begin
               width  = '0;
               height = gara_pkg::RECT_W'($urandom_range(0, 1023));
            end else begin
               width  = gara_pkg::RECT_W'($urandom_range(0, 1023));
               height = '0;
            end
         end else if (pick < 8) begin
            if ($urandom_range(0, 1) == 1) begin
               width  = gara_pkg::RECT_W'($urandom_range(513, 1023));
               height = gara_pkg::RECT_W'($urandom_range(0, 1023));
            end else begin
               width  = gara_pkg::RECT_W'($urandom_range(0, 1023));
               height = gara_pkg::RECT_W'($urandom_range(513, 1023));
            end
         end else if (pick < 11) begin
            width  = gara_pkg::RECT_W'($urandom_range(64, 512));
            height = gara_pkg::RECT_W'($urandom_range(64, 512));
         end else begin
            width  = gara_pkg::RECT_W'($urandom_range(1, 96));
            height = gara_pkg::RECT_W'($urandom_range(1, 96));
         end
         send_rect(width, height);
      end
   endtask

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d responses outstanding",
               cycle_count, placements_due.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_rect_width  = '0;
      req_rect_height = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed requests run with a lightly idling sender. The block sweeps its
      // store after reset; send_rect simply waits through that while busy is high.
      sender_idle_pct = 15;
      test_zero_size();
      test_rounding();
      test_oversize();
      test_full_page();

      // Random fill in three stretches: light sender gaps, heavy gaps, none.
      test_random_fill(150, 15);
      test_random_fill(150, 54);
      test_random_fill(150, 0);

      // Drop start so no further transfer happens, wait for every response, then
      // keep watching long enough that a stray strobe would be caught.
      start <= 1'b0;
      while (placements_due.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d rectangle requests: %0d placed in open pages, %0d opened pages,",
               requests_sent, placed_count, opened_count);
      $display("%0d refused for lack of space; %0d responses checked in %0d cycles.",
               refused_count, responses_checked, cycle_count);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/gara_pkg.sv
hw/rtl/gara_ram.sv
hw/rtl/gara_shifter.sv
hw/rtl/grid_atlas_rect_allocator.sv
tb/sv/tb.sv
